@@ rtl/mpjd_pkg.sv @@
// Shared types, codes and constants for the multi-policy job dispatcher.
package mpjd_pkg;

    localparam int MAX_JOBS_DEF = 32;

    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int WORD_W  = ID_W + PRIO_W + BURST_W;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    localparam logic [1:0] STS_ACCEPTED = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_SLICE    = 2'd2;
    localparam logic [1:0] STS_NO_WORK  = 2'd3;

    localparam logic [1:0] POL_SJF  = 2'd0;
    localparam logic [1:0] POL_FCFS = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_RR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICE = 1'd1;

    localparam logic [1:0] POLICY_RESET     = POL_SJF;
    localparam logic [7:0] TIME_SLICE_RESET = 8'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic scan_step;
        logic exec_simple;
        logic finish_dispatch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_dispatch;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/multi_policy_job_dispatcher.sv @@
// Top level of the multi-policy job dispatcher: controller, datapath and checks.
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  one request: load, dispatch or clear
//  m_        out        m_tvalid/m_tready  one result for each request
//  cfg_      in         cfg_we             policy and time slice registers
//
// A dispatch request scans the job table, which has a single read port, and the scan
// reads one entry a cycle; load and clear requests skip the scan.
// Reset is synchronous and active low; the job table needs no clearing pass.
// A finished result waits in the output register while the next request is accepted;
// the following result is issued only once that register has been taken.
module multi_policy_job_dispatcher #(
    parameter int MAX_JOBS = mpjd_pkg::MAX_JOBS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[1:0], job_id[17:2], burst_time[33:18], job_priority[41:34], zeros above
    input  logic [mpjd_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], run_job_id[17:2], run_time[33:18], job_finished[34], zeros above
    output logic [mpjd_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_we,
    input  logic [mpjd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpjd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import mpjd_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    mpjd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    mpjd_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctrl_cmd),
        .status    (dp_status)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl_cmd.accept, ctrl_cmd.start_scan, ctrl_cmd.scan_step,
                  ctrl_cmd.exec_simple, ctrl_cmd.finish_dispatch}))
        else $error("More than one controller command in a cycle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(ctrl_cmd.exec_simple || ctrl_cmd.finish_dispatch))
        else $error("Result issued over one that has not been taken.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.accept |=> !s_tready)
        else $error("Second request accepted before the first was finished.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.scan_step |-> !dp_status.scan_done)
        else $error("Table read issued beyond the loaded entries.");

endmodule

@@ rtl/mpjd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mpjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mpjd_ctrl.sv @@
// Controller state machine sequencing request intake, table scan and result issue.
module mpjd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mpjd_pkg::dp_status_t   status,
    output mpjd_pkg::ctrl_cmd_t    cmd
);

    import mpjd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.req_dispatch) begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end else if (status.out_free) begin
                    cmd.exec_simple = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish_dispatch = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mpjd_dp.sv @@
// Datapath holding the job table, scan selection logic, configuration and result register.
module mpjd_dp #(
    parameter int MAX_JOBS = mpjd_pkg::MAX_JOBS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [mpjd_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mpjd_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 cfg_we,
    input  logic [mpjd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpjd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  mpjd_pkg::ctrl_cmd_t                  cmd,
    output mpjd_pkg::dp_status_t                 status
);

    import mpjd_pkg::*;

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_JOBS);

    logic [1:0]         policy_reg;
    logic [7:0]         time_slice_reg;

    logic [1:0]         req_action_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [BURST_W-1:0] req_burst_reg;
    logic [PRIO_W-1:0]  req_prio_reg;

    logic [CW-1:0]      job_count_reg;
    logic [CW-1:0]      job_count_next;
    logic [IW-1:0]      rr_ptr_reg;
    logic [IW-1:0]      rr_ptr_next;

    logic [CW-1:0]      scan_cnt_reg;
    logic [CW-1:0]      scan_cnt_next;
    logic [IW-1:0]      scan_addr_reg;
    logic [IW-1:0]      scan_addr_next;
    logic               rd_vld_reg;
    logic [IW-1:0]      rd_idx_reg;

    logic               found_reg;
    logic               found_next;
    logic [IW-1:0]      best_idx_reg;
    logic [IW-1:0]      best_idx_next;
    logic [WORD_W-1:0]  best_word_reg;
    logic [WORD_W-1:0]  best_word_next;

    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [1:0]         out_status_reg;
    logic [1:0]         out_status_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [ID_W-1:0]    out_id_next;
    logic [BURST_W-1:0] out_time_reg;
    logic [BURST_W-1:0] out_time_next;
    logic               out_fin_reg;
    logic               out_fin_next;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    logic [CW-1:0]      addr_inc;
    logic [CW-1:0]      ptr_inc;
    logic [BURST_W-1:0] cand_burst;
    logic [PRIO_W-1:0]  cand_prio;
    logic [BURST_W-1:0] best_burst;
    logic [PRIO_W-1:0]  best_prio;
    logic [BURST_W-1:0] quantum;
    logic [BURST_W-1:0] grant;
    logic [BURST_W-1:0] rem_left;
    logic               take;

    mpjd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_step),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    assign cand_burst = ram_rdata[BURST_W-1:0];
    assign cand_prio  = ram_rdata[BURST_W+PRIO_W-1:BURST_W];
    assign best_burst = best_word_reg[BURST_W-1:0];
    assign best_prio  = best_word_reg[BURST_W+PRIO_W-1:BURST_W];

    assign addr_inc = CW'(scan_addr_reg) + CW'(1);
    assign ptr_inc  = CW'(best_idx_reg) + CW'(1);

    assign quantum  = (time_slice_reg == 8'd0) ? BURST_W'(1) : BURST_W'(time_slice_reg);
    assign grant    = (policy_reg == POL_RR && quantum < best_burst) ? quantum : best_burst;
    assign rem_left = best_burst - grant;

    assign take = rd_vld_reg && (cand_burst != '0) &&
                  (!found_reg ||
                   (policy_reg == POL_SJF  && cand_burst < best_burst) ||
                   (policy_reg == POL_PRIO && cand_prio  < best_prio));

    always_comb begin
        job_count_next  = job_count_reg;
        rr_ptr_next     = rr_ptr_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_addr_next  = scan_addr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_word_next  = best_word_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_time_next   = out_time_reg;
        out_fin_next    = out_fin_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = {best_word_reg[WORD_W-1:BURST_W], rem_left};

        if (cmd.start_scan) begin
            scan_cnt_next = '0;
            found_next    = 1'b0;
            if (policy_reg == POL_RR && CW'(rr_ptr_reg) < job_count_reg) begin
                scan_addr_next = rr_ptr_reg;
            end else begin
                scan_addr_next = '0;
            end
        end

        if (cmd.scan_step) begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
            if (addr_inc == job_count_reg) begin
                scan_addr_next = '0;
            end else begin
                scan_addr_next = addr_inc[IW-1:0];
            end
        end

        if (take) begin
            found_next     = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_word_next = ram_rdata;
        end

        if (cmd.exec_simple) begin
            m_tvalid_next   = 1'b1;
            out_status_next = STS_ACCEPTED;
            out_id_next     = '0;
            out_time_next   = '0;
            out_fin_next    = 1'b0;
            case (req_action_reg)
                ACT_LOAD: begin
                    if (job_count_reg == FULL_COUNT) begin
                        out_status_next = STS_FULL;
                    end else begin
                        ram_we         = 1'b1;
                        ram_waddr      = job_count_reg[IW-1:0];
                        ram_wdata      = {req_id_reg, req_prio_reg, req_burst_reg};
                        job_count_next = job_count_reg + CW'(1);
                    end
                end
                ACT_CLEAR: begin
                    job_count_next = '0;
                    rr_ptr_next    = '0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.finish_dispatch) begin
            m_tvalid_next = 1'b1;
            if (found_reg) begin
                ram_we          = 1'b1;
                out_status_next = STS_SLICE;
                out_id_next     = best_word_reg[WORD_W-1:BURST_W+PRIO_W];
                out_time_next   = grant;
                out_fin_next    = (rem_left == '0);
                if (policy_reg == POL_RR) begin
                    if (ptr_inc >= job_count_reg) begin
                        rr_ptr_next = '0;
                    end else begin
                        rr_ptr_next = ptr_inc[IW-1:0];
                    end
                end
            end else begin
                out_status_next = STS_NO_WORK;
                out_id_next     = '0;
                out_time_next   = '0;
                out_fin_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg     <= POLICY_RESET;
            time_slice_reg <= TIME_SLICE_RESET;
            job_count_reg  <= '0;
            rr_ptr_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_POLICY) begin
                policy_reg <= cfg_wdata[1:0];
            end
            if (cfg_we && cfg_index == REG_TIME_SLICE) begin
                time_slice_reg <= cfg_wdata;
            end
            job_count_reg <= job_count_next;
            rr_ptr_reg    <= rr_ptr_next;
            rd_vld_reg    <= cmd.scan_step;
            found_reg     <= found_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_action_reg <= s_tdata[1:0];
            req_id_reg     <= s_tdata[17:2];
            req_burst_reg  <= s_tdata[33:18];
            req_prio_reg   <= s_tdata[41:34];
        end
        scan_cnt_reg   <= scan_cnt_next;
        scan_addr_reg  <= scan_addr_next;
        rd_idx_reg     <= scan_addr_reg;
        best_idx_reg   <= best_idx_next;
        best_word_reg  <= best_word_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_time_reg   <= out_time_next;
        out_fin_reg    <= out_fin_next;
    end

    assign status.req_dispatch = (req_action_reg == ACT_DISPATCH);
    assign status.scan_done    = (scan_cnt_reg == job_count_reg);
    assign status.out_free     = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_fin_reg, out_time_reg, out_id_reg, out_status_reg};

endmodule

@@ bench/dispatch_checker.sv @@
`timescale 1ns / 1ps
// Checker for the job dispatcher: predicts each result from the accepted requests and compares.
module dispatch_checker
    import mpjd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    waiting_results
);

    localparam int DEPTH = MAX_JOBS_DEF;

    typedef struct packed {
        logic        finished;
        logic [15:0] granted;
        logic [15:0] job;
        logic [1:0]  status;
    } slice_t;

    logic [15:0] left_burst [DEPTH];
    logic [7:0]  job_prio   [DEPTH];
    logic [15:0] job_ident  [DEPTH];
    int          loaded;
    int          rr_next;
    logic [1:0]  cur_policy;
    logic [7:0]  quantum;
    slice_t      pending_slices [$];
    int          errors = 0;

    function automatic int choose_job();
        int best;
        int start;
        int idx;
        best = DEPTH;
        if (cur_policy == POL_RR) begin
            start = (rr_next < loaded) ? rr_next : 0;
            for (int i = 0; i < loaded; i++) begin
                idx = start + i;
                if (idx >= loaded)
                    idx -= loaded;
                if (left_burst[idx] != 16'd0)
                    return idx;
            end
            return DEPTH;
        end
        for (int i = 0; i < loaded; i++) begin
            if (left_burst[i] == 16'd0)
                continue;
            if (best == DEPTH) begin
                best = i;
                if (cur_policy == POL_FCFS)
                    return best;
            end else if (cur_policy == POL_SJF) begin
                if (left_burst[i] < left_burst[best])
                    best = i;
            end else if (cur_policy == POL_PRIO) begin
                if (job_prio[i] < job_prio[best])
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic slice_t predict_slice(input logic [S_DATA_W-1:0] word);
        slice_t      r;
        int          j;
        logic [15:0] grant;
        logic [7:0]  q;
        r = '0;
        r.status = STS_ACCEPTED;
        case (word[1:0])
            ACT_LOAD: begin
                if (loaded < DEPTH) begin
                    job_ident[loaded]  = word[17:2];
                    left_burst[loaded] = word[33:18];
                    job_prio[loaded]   = word[41:34];
                    loaded++;
                end else begin
                    r.status = STS_FULL;
                end
            end
            ACT_DISPATCH: begin
                j = choose_job();
                if (j == DEPTH) begin
                    r.status = STS_NO_WORK;
                end else begin
                    grant = left_burst[j];
                    if (cur_policy == POL_RR) begin
                        q = (quantum == 8'd0) ? 8'd1 : quantum;
                        if ({8'd0, q} < grant)
                            grant = {8'd0, q};
                        rr_next = (j + 1 >= loaded) ? 0 : j + 1;
                    end
                    left_burst[j] = left_burst[j] - grant;
                    r.status   = STS_SLICE;
                    r.job      = job_ident[j];
                    r.granted  = grant;
                    r.finished = (left_burst[j] == 16'd0);
                end
            end
            ACT_CLEAR: begin
                loaded  = 0;
                rr_next = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        slice_t got;
        slice_t want;
        if (!aresetn) begin
            loaded     = 0;
            rr_next    = 0;
            cur_policy = POLICY_RESET;
            quantum    = TIME_SLICE_RESET;
            pending_slices.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[34:0];
                if (pending_slices.size() == 0) begin
                    errors++;
                    $display("%0t: expected no result, actual status %0d id %h time %0d fin %0d",
                             $time, got.status, got.job, got.granted, got.finished);
                end else begin
                    want = pending_slices.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected status %0d id %h time %0d fin %0d, %s %0d %s",
                                 $time, want.status, want.job, want.granted, want.finished,
                                 "actual status", got.status, "(see next line)");
                        $display("%0t:   actual   status %0d id %h time %0d fin %0d",
                                 $time, got.status, got.job, got.granted, got.finished);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_slices.push_back(predict_slice(s_tdata));
            if (cfg_we) begin
                if (cfg_index == REG_POLICY)
                    cur_policy = cfg_wdata[1:0];
                else if (cfg_index == REG_TIME_SLICE)
                    quantum = cfg_wdata;
            end
        end
        fail_count      <= errors;
        waiting_results <= pending_slices.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the job dispatcher testbench: clock, reset, request stimulus and the verdict.
module tb_top;
    import mpjd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    waiting_results;
    int                    sent = 0;
    bit                    calm = 1'b0;
    int                    stall_asks = 0;

    multi_policy_job_dispatcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    dispatch_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .waiting_results(waiting_results)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic send_req(input logic [1:0] act, input logic [15:0] id = 16'h0,
                            input logic [15:0] burst = 16'h0, input logic [7:0] prio = 8'h0);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, prio, burst, id, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting_results != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] pol, input logic [7:0] slice);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_POLICY;
        cfg_wdata <= {6'b0, pol};
        @(posedge aclk);
        cfg_index <= REG_TIME_SLICE;
        cfg_wdata <= slice;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_burst();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [7:0] pick_prio();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 3));
    endfunction

    initial begin
        int         seq;
        int         jobs;
        int         cap;
        int         r;
        logic [7:0] slice;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_req(ACT_DISPATCH);
        send_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_req(ACT_LOAD, 16'h0000, 16'hFFFF, 8'hFF);
        send_req(ACT_LOAD, 16'hFFFF, 16'h0000, 8'h00);
        send_req(ACT_LOAD, 16'h1234, 16'd3, 8'd7);
        send_req(ACT_LOAD, 16'hABCD, 16'd3, 8'd7);
        repeat (3) send_req(ACT_DISPATCH);
        set_config(POL_RR, 8'd0);
        send_req(ACT_LOAD, 16'h5555, 16'd2, 8'd0);
        repeat (3) send_req(ACT_DISPATCH);
        set_config(POL_PRIO, 8'd255);
        send_req(ACT_LOAD, 16'hAAAA, 16'd4, 8'd0);
        repeat (2) send_req(ACT_DISPATCH);
        set_config(POL_FCFS, 8'd1);
        repeat (2) send_req(ACT_DISPATCH);
        send_req(ACT_CLEAR);
        send_req(ACT_DISPATCH);

        seq = 0;
        while (sent < 1650) begin
            if (sent > 1400)
                calm = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: slice = 8'd0;
                    1: slice = 8'd1;
                    2: slice = 8'd255;
                    default: slice = 8'($urandom_range(1, 12));
                endcase
                set_config(2'($urandom_range(0, 3)), slice);
            end else if (seq % 10 == 5) begin
                drain();
            end
            // The receiver holds off here while the loads below pile up behind it.
            if (seq == 3)
                stall_asks++;
            if ($urandom_range(0, 7) != 0)
                send_req(ACT_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
            jobs = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
            repeat (jobs) send_req(ACT_LOAD, 16'($urandom), pick_burst(), pick_prio());
            cap = $urandom_range(jobs, 3 * jobs + 4);
            if (cap > 60)
                cap = 60;
            repeat (cap) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_req(ACT_LOAD, 16'($urandom), pick_burst(), pick_prio());
                else if (r == 1)
                    send_req(ACT_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
                else
                    send_req(ACT_DISPATCH, 16'($urandom), 16'($urandom), 8'($urandom));
            end
            seq++;
        end

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : receiver
        int served;
        served = 0;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (served != stall_asks) begin
                served++;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mpjd_pkg.sv
rtl/mpjd_ram.sv
rtl/mpjd_ctrl.sv
rtl/mpjd_dp.sv
rtl/multi_policy_job_dispatcher.sv
bench/dispatch_checker.sv
bench/tb_top.sv
